### src/assert_macros.svh
// Assertion macros shared by the line assembler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/sla_pkg.sv
// Shared constants and types of the serial line assembler.
package sla_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int RAM_DEPTH  = 2 * LINE_DEPTH;
  localparam int RAM_AW     = IDX_W + 1;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_DEPTH - 2);

  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTER  = 1'b1;

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd27;
  localparam logic [BYTE_W-1:0] ENTER_RESET  = 8'd13;

  typedef struct packed {
    logic             bank;
    logic [IDX_W-1:0] len;
    logic             empty;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic              bank;
  } bank_rel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic              last_byte;
    logic              empty_line;
  } result_t;

endpackage

### src/sla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/sla_front.sv
// Front end: configuration, byte classification, line store writes and line commands.
`include "assert_macros.svh"
module sla_front import sla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 push,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 full,
  output logic                 ram_wr_en,
  output logic [RAM_AW-1:0]    ram_wr_addr,
  output logic [BYTE_W-1:0]    ram_wr_data,
  output logic                 cmd_push,
  output cmd_t                 cmd,
  input  logic                 cmd_full,
  input  bank_rel_t            rel
);

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              bank_r, bank_nxt;
  logic [1:0]        busy_r, busy_nxt;
  logic [BYTE_W-1:0] escape_r, escape_nxt;
  logic [BYTE_W-1:0] enter_r, enter_nxt;

  logic              accept;
  logic              is_esc;
  logic              is_ent;
  logic              at_end;
  logic [IDX_W-1:0]  idx_adv;
  logic [IDX_W-1:0]  line_len;

  always_comb begin
    full     = cmd_full | busy_r[bank_r];
    accept   = push & ~full;
    is_esc   = (rx_byte == escape_r);
    is_ent   = ~is_esc & (rx_byte == enter_r);
    at_end   = (idx_r == LAST_IDX);
    idx_adv  = at_end ? '0 : idx_r + IDX_W'(1);
    line_len = at_end ? '0 : idx_r;

    ram_wr_en   = accept;
    ram_wr_addr = {bank_r, idx_r};
    ram_wr_data = rx_byte;

    cmd_push = accept & is_ent;
    cmd      = '{bank: bank_r, len: line_len, empty: (line_len == '0)};

    idx_nxt  = idx_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      priority if (is_esc) begin
        idx_nxt = '0;
      end else if (is_ent) begin
        idx_nxt = '0;
        if (line_len != '0) begin
          busy_nxt[bank_r] = 1'b1;
          bank_nxt         = ~bank_r;
        end
      end else begin
        idx_nxt = idx_adv;
      end
    end

    escape_nxt = escape_r;
    enter_nxt  = enter_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ESCAPE: escape_nxt = cfg_data;
        REG_ENTER:  enter_nxt  = cfg_data;
        default:    escape_nxt = escape_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      bank_r   <= 1'b0;
      busy_r   <= '0;
      escape_r <= ESCAPE_RESET;
      enter_r  <= ENTER_RESET;
    end else begin
      idx_r    <= idx_nxt;
      bank_r   <= bank_nxt;
      busy_r   <= busy_nxt;
      escape_r <= escape_nxt;
      enter_r  <= enter_nxt;
    end
  end

  `ASSERT_ALWAYS(a_idx_range, idx_r <= LAST_IDX, "write index beyond line range")
  `ASSERT_IMPLIES(a_write_free_bank, ram_wr_en, !busy_r[bank_r], "write into busy bank")

endmodule

### src/sla_cmdq.sv
// Two-entry command queue between front and back end.
`include "assert_macros.svh"
module sla_cmdq import sla_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    full    = (cnt_r == 2'd2);
    empty   = (cnt_r == 2'd0);
    head    = q_r[rp_r];
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_cmd;
    end
  end

  `ASSERT_ALWAYS(a_cmdq_flow, !(push && full) && !(pop && empty), "command queue misuse")

endmodule

### src/sla_back.sv
// Back end: line readout from the store into a two-entry result queue.
`include "assert_macros.svh"
module sla_back import sla_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  cmd_t              cmd_head,
  output logic              cmd_pop,
  output logic              ram_rd_en,
  output logic [RAM_AW-1:0] ram_rd_addr,
  input  logic [BYTE_W-1:0] ram_rd_data,
  output bank_rel_t         rel,
  output logic              empty,
  input  logic              pop,
  output result_t           head
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             pend_r;
  logic             pend_last_r;
  result_t          of_r [2];
  logic             owp_r, owp_nxt;
  logic             orp_r, orp_nxt;
  logic [1:0]       ocnt_r, ocnt_nxt;

  logic             room;
  logic             is_last;
  logic             empty_push;
  logic             res_push;
  logic             res_pop;
  result_t          res_data;

  always_comb begin
    room        = ((ocnt_r + {1'b0, pend_r}) < 2'd2);
    is_last     = (k_r == cmd_r.len - IDX_W'(1));
    ram_rd_addr = {cmd_r.bank, k_r};
    ram_rd_en   = 1'b0;
    cmd_pop     = 1'b0;
    empty_push  = 1'b0;
    rel         = '0;
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    k_nxt       = k_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_head.empty) begin
            if (!pend_r && ocnt_r != 2'd2) begin
              cmd_pop    = 1'b1;
              empty_push = 1'b1;
            end
          end else begin
            cmd_pop   = 1'b1;
            cmd_nxt   = cmd_head;
            k_nxt     = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (room) begin
          ram_rd_en = 1'b1;
          if (is_last) begin
            rel       = '{valid: 1'b1, bank: cmd_r.bank};
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    res_push = pend_r | empty_push;
    res_data = pend_r ? result_t'{line_byte: ram_rd_data, last_byte: pend_last_r,
                                  empty_line: 1'b0}
                      : result_t'{line_byte: '0, last_byte: 1'b1, empty_line: 1'b1};
    empty    = (ocnt_r == 2'd0);
    head     = of_r[orp_r];
    res_pop  = pop & ~empty;
    owp_nxt  = res_push ? ~owp_r : owp_r;
    orp_nxt  = res_pop ? ~orp_r : orp_r;
    ocnt_nxt = ocnt_r + {1'b0, res_push} - {1'b0, res_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      owp_r   <= 1'b0;
      orp_r   <= 1'b0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= ram_rd_en;
      owp_r   <= owp_nxt;
      orp_r   <= orp_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    k_r         <= k_nxt;
    pend_last_r <= is_last;
    if (res_push) begin
      of_r[owp_r] <= res_data;
    end
  end

  `ASSERT_IMPLIES(a_k_in_line, state_r == ST_RUN, k_r < cmd_r.len, "read index past line")
  `ASSERT_ALWAYS(a_res_no_ovf, !(res_push && !res_pop && ocnt_r == 2'd2), "result overflow")

endmodule

### src/serial_line_assembler.sv
// Top level of the serial line assembler.
// Received bytes enter at one per cycle while full is low and are written into a
// line store of two banks of LINE_DEPTH entries; escape drops the line, enter
// queues it for readout. The readout issues a store read only while the registered
// read of the store and the two-entry result queue leave room for its data, so new
// reads can start while earlier bytes still wait in the queue; an empty line passes
// through the command and result queues and offers a single result flagged empty_line.
// One line can fill while the previous one drains; full rises when both banks hold
// lines not yet read out or two line commands are waiting.
// Configuration writes take effect at the next edge and are meant for idle time.
module serial_line_assembler import sla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [BYTE_W-1:0]    out_line_byte,
  output logic                 out_last_byte,
  output logic                 out_empty_line
);

  logic              ram_wr_en;
  logic [RAM_AW-1:0] ram_wr_addr;
  logic [BYTE_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [RAM_AW-1:0] ram_rd_addr;
  logic [BYTE_W-1:0] ram_rd_data;
  logic              cmd_push;
  cmd_t              cmd_in;
  logic              cmd_full;
  logic              cmd_pop;
  logic              cmd_empty;
  cmd_t              cmd_head;
  bank_rel_t         rel;
  result_t           res;

  sla_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .rx_byte    (in_rx_byte),
    .full       (full),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .cmd_full   (cmd_full),
    .rel        (rel)
  );

  sla_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  sla_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .push_cmd(cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .empty   (cmd_empty),
    .head    (cmd_head)
  );

  sla_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd_head   (cmd_head),
    .cmd_pop    (cmd_pop),
    .ram_rd_en  (ram_rd_en),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data),
    .rel        (rel),
    .empty      (empty),
    .pop        (pop),
    .head       (res)
  );

  assign out_line_byte  = res.line_byte;
  assign out_last_byte  = res.last_byte;
  assign out_empty_line = res.empty_line;

endmodule
